/* design/dhpe_pkg.sv */
// Shared types, character constants and hex conversion for the delta hex encoder.
package dhpe_pkg;

  // ASCII codes used in the encoded stream.
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A       = 8'h61;

  // Character positions within the encoded sequence of one word.
  localparam logic [2:0] POS_PCT_BYTE = 3'd0;
  localparam logic [2:0] POS_HI_BYTE  = 3'd1;
  localparam logic [2:0] POS_LO_BYTE  = 3'd2;
  localparam logic [2:0] POS_PCT_SUM  = 3'd3;
  localparam logic [2:0] POS_HI_SUM   = 3'd4;
  localparam logic [2:0] POS_LO_SUM   = 3'd5;

  // One encoded word waiting for serialisation.
  typedef struct packed {
    logic [7:0] delta;
    logic [7:0] sum_delta;
    logic       ends;
  } dhpe_item_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_A + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

/* design/dhpe_delta.sv */
// Input stage: message state, byte and checksum differences, one-item buffer.
module dhpe_delta
  import dhpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_message_byte,
  input  logic       in_end_of_message,
  output logic       item_valid,
  output dhpe_item_t item,
  input  logic       item_pop
);

  logic [7:0] prev_r, prev_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       buf_valid_r;
  dhpe_item_t buf_r, buf_nxt;
  logic       accept;
  logic [7:0] new_sum;

  // The buffer takes a new word when empty or when it is drained this cycle.
  assign in_stall = buf_valid_r && !item_pop;
  assign accept   = in_valid && !in_stall;

  // Differences and the running sum for the arriving word.
  always_comb begin
    new_sum           = sum_r + in_message_byte;
    buf_nxt.delta     = in_message_byte - prev_r;
    buf_nxt.sum_delta = new_sum - in_message_byte;
    buf_nxt.ends      = in_end_of_message;
    if (in_end_of_message) begin
      prev_nxt = 8'd0;
      sum_nxt  = 8'd0;
    end else begin
      prev_nxt = in_message_byte;
      sum_nxt  = new_sum;
    end
  end

  // State and buffer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 8'd0;
      sum_r       <= 8'd0;
      buf_valid_r <= 1'b0;
    end else if (accept) begin
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      buf_valid_r <= 1'b1;
    end else if (item_pop) begin
      buf_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= buf_nxt;
    end
  end

  assign item_valid = buf_valid_r;
  assign item       = buf_r;

endmodule

/* design/dhpe_serial.sv */
// Output stage: walks the characters of each word into the result register.
module dhpe_serial
  import dhpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  dhpe_item_t item,
  output logic       item_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic       cur_valid_r;
  dhpe_item_t cur_r;
  logic [2:0] pos_r;
  logic       out_valid_r;
  logic [7:0] out_char_r, char_nxt;
  logic       out_last_r;
  logic       advance;
  logic       finish;

  // A character moves into the result register when it is empty or taken.
  assign advance  = cur_valid_r && (!out_valid_r || !out_stall);
  assign finish   = advance && ((pos_r == POS_LO_BYTE && !cur_r.ends) ||
                                pos_r == POS_LO_SUM);
  assign item_pop = item_valid && (!cur_valid_r || finish);

  // Character for the current position.
  always_comb begin
    case (pos_r)
      POS_PCT_BYTE: char_nxt = CHAR_PERCENT;
      POS_HI_BYTE:  char_nxt = hex_char(cur_r.delta[7:4]);
      POS_LO_BYTE:  char_nxt = hex_char(cur_r.delta[3:0]);
      POS_PCT_SUM:  char_nxt = CHAR_PERCENT;
      POS_HI_SUM:   char_nxt = hex_char(cur_r.sum_delta[7:4]);
      POS_LO_SUM:   char_nxt = hex_char(cur_r.sum_delta[3:0]);
      default:      char_nxt = CHAR_PERCENT;
    endcase
  end

  // Sequencer for the current word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= POS_PCT_BYTE;
    end else if (item_pop) begin
      cur_valid_r <= 1'b1;
      pos_r       <= POS_PCT_BYTE;
    end else if (finish) begin
      cur_valid_r <= 1'b0;
      pos_r       <= POS_PCT_BYTE;
    end else if (advance) begin
      pos_r <= pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur_r <= item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= char_nxt;
      out_last_r <= (pos_r == POS_LO_SUM);
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

/* design/delta_hex_percent_encoder.sv */
// Top level of the delta hex percent encoder.
//
//   Channel | Handshake            | Word
//   --------+----------------------+--------------------------------------
//   in_     | in_valid / in_stall  | in_message_byte, in_end_of_message
//   out_    | out_valid / out_stall| out_char, out_last
//
// Each input word yields three characters, or six on the final byte of a
// message; the pace is set by the single character result register, and the
// one-word buffer can take the next byte while the current word is being sent.
// Reset (rst_n low, synchronous) clears the previous byte, the checksum and all
// valid flags. A held out_stall backs up into in_stall once the one-word buffer is full.
module delta_hex_percent_encoder
  import dhpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_message_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic       item_valid;
  dhpe_item_t item;
  logic       item_pop;

  // Difference and checksum stage.
  dhpe_delta u_delta (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_message_byte   (in_message_byte),
    .in_end_of_message (in_end_of_message),
    .item_valid        (item_valid),
    .item              (item),
    .item_pop          (item_pop)
  );

  // Character serialiser.
  dhpe_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule
